// ----- sv/ftpbs_pkg.sv -----
package ftpbs_pkg;

  // Field widths
  localparam int unsigned ChanW  = 9;
  localparam int unsigned MagW   = 24;
  localparam int unsigned SnrW   = 16;
  localparam int unsigned CntW   = 16;
  localparam int unsigned SumW   = 17;
  localparam int unsigned FrameW = 15;
  localparam int unsigned BaudW  = 16;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegFrameSamples = 2'd0;
  localparam logic [CfgIdxW-1:0] RegBaudSamples  = 2'd1;

  // Reset values
  localparam logic [FrameW-1:0] FrameReset = 15'd564;
  localparam logic [BaudW-1:0]  BaudReset  = 16'd1056;

  // SNR limits, Q8.8
  localparam logic [SnrW-1:0] SnrMin = 16'd256;
  localparam logic [SnrW-1:0] SnrMax = 16'hFFFF;

  // Decay factor 51/1024 with half-LSB rounding
  localparam logic [5:0]  DecayMul   = 6'd51;
  localparam logic [22:0] DecayRound = 23'd512;

  typedef enum logic [1:0] {
    LVL_NONE,
    LVL_MARK,
    LVL_SPACE
  } level_e;

  // Item state in the divider stages
  typedef struct packed {
    logic [ChanW-1:0] chan;
    logic [ChanW-1:0] rem;   // channel being reduced to a state index
    level_e           lvl;
    logic             sat;
    logic [MagW-1:0]  dvs;   // noise floor, never zero
    logic [MagW:0]    prem;  // partial remainder
    logic [SnrW-1:0]  qn;    // dividend bits in, quotient bits out
  } stage_t;

  // Per-channel stored state
  typedef struct packed {
    logic [CntW-1:0] cnt;
    logic [SumW-1:0] sum;
    logic [SnrW-1:0] snr;
  } chan_state_t;

  // One restoring division step
  function automatic stage_t div_step(stage_t s);
    stage_t     r;
    logic [MagW:0] r2;
    r  = s;
    r2 = {s.prem[MagW-1:0], s.qn[SnrW-1]};
    if (r2 >= {1'b0, s.dvs}) begin
      r.prem = r2 - {1'b0, s.dvs};
      r.qn   = {s.qn[SnrW-2:0], 1'b1};
    end else begin
      r.prem = r2;
      r.qn   = {s.qn[SnrW-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

// ----- sv/fsk_tone_pair_bit_slicer.sv -----
// Channel  Direction  Handshake                 Payload
// in       sink       in_valid_i / in_stall_o   channel_i, space_mag_i, mark_mag_i, noise_floor_i
// out      source     out_valid_o / out_stall_i channel_out_o, bit_valid_o, bit_value_o, snr_level_o
// cfg      sink       cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One item per cycle while in_stall_o is low. Stages: input register, 8 divider stages of 2
// quotient bits each, one state update stage, one output stage.
// After reset a clearing pass writes NUM_CHANNELS memory rows, one a cycle, with in_stall_o high.
// When a result waits under out_stall_i the whole pipeline holds; bubbles hold nothing.
// Back-to-back items on one channel are served by a bypass around the memory.
module fsk_tone_pair_bit_slicer #(
  parameter int unsigned NUM_CHANNELS = 512
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [ftpbs_pkg::ChanW-1:0]        channel_i,
  input  logic [ftpbs_pkg::MagW-1:0]         space_mag_i,
  input  logic [ftpbs_pkg::MagW-1:0]         mark_mag_i,
  input  logic [ftpbs_pkg::MagW-1:0]         noise_floor_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [ftpbs_pkg::ChanW-1:0]        channel_out_o,
  output logic                               bit_valid_o,
  output logic                               bit_value_o,
  output logic [ftpbs_pkg::SnrW-1:0]         snr_level_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [ftpbs_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [ftpbs_pkg::CfgDataW-1:0]     cfg_data_i
);

  localparam int unsigned IdxW   = $clog2(NUM_CHANNELS);
  localparam int unsigned NStage = 8;

  // Channel reduction: one conditional subtract of NUM_CHANNELS << k
  function automatic logic [ftpbs_pkg::ChanW-1:0] mod_step(
    logic [ftpbs_pkg::ChanW-1:0] r, int unsigned k);
    logic [31:0] m;
    m = 32'(NUM_CHANNELS) << k;
    if (32'(r) >= m) return ftpbs_pkg::ChanW'(32'(r) - m);
    return r;
  endfunction

  // Configuration registers
  logic [ftpbs_pkg::FrameW-1:0] frame_q;
  logic [ftpbs_pkg::BaudW-1:0]  baud_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q <= ftpbs_pkg::FrameReset;
      baud_q  <= ftpbs_pkg::BaudReset;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == ftpbs_pkg::RegFrameSamples) begin
        frame_q <= cfg_data_i[ftpbs_pkg::FrameW-1:0];
      end else if (cfg_index_i == ftpbs_pkg::RegBaudSamples) begin
        baud_q <= cfg_data_i;
      end
    end
  end

  // Pipeline control
  logic                     adv;
  logic                     clr_busy_q;
  logic [IdxW-1:0]          clr_cnt_q;
  logic [NStage:0]          v_q;     // stages 0..8
  logic                     v9_q;
  logic                     out_vld_q;

  assign adv        = !(out_vld_q && out_stall_i);
  assign in_stall_o = clr_busy_q || !adv;

  // Input stage logic
  ftpbs_pkg::stage_t in_s;
  logic [ftpbs_pkg::MagW-1:0] fl, peak;

  always_comb begin
    fl   = (noise_floor_i == '0) ? ftpbs_pkg::MagW'(1) : noise_floor_i;
    peak = (mark_mag_i > space_mag_i) ? mark_mag_i : space_mag_i;
    in_s.chan = channel_i;
    in_s.rem  = channel_i;
    in_s.dvs  = fl;
    in_s.sat  = ({8'b0, peak} >= {fl, 8'b0});
    in_s.prem = {9'b0, peak[ftpbs_pkg::MagW-1:8]};
    in_s.qn   = {peak[7:0], 8'b0};
    if ({2'b0, peak} < {fl, 2'b0}) begin
      in_s.lvl = ftpbs_pkg::LVL_NONE;
    end else if ({1'b0, mark_mag_i} > {space_mag_i, 1'b0}) begin
      in_s.lvl = ftpbs_pkg::LVL_MARK;
    end else if ({1'b0, space_mag_i} > {mark_mag_i, 1'b0}) begin
      in_s.lvl = ftpbs_pkg::LVL_SPACE;
    end else begin
      in_s.lvl = ftpbs_pkg::LVL_NONE;
    end
  end

  // Divider stages, two quotient bits and one reduction step each
  ftpbs_pkg::stage_t pipe_q [NStage+1];
  ftpbs_pkg::stage_t pipe_d [NStage+1];

  always_comb begin
    pipe_d[0] = in_s;
    for (int unsigned k = 1; k <= NStage; k++) begin
      pipe_d[k]     = ftpbs_pkg::div_step(ftpbs_pkg::div_step(pipe_q[k-1]));
      pipe_d[k].rem = mod_step(pipe_q[k-1].rem, NStage + 1 - k);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int unsigned k = 0; k <= NStage; k++) begin
        pipe_q[k] <= pipe_d[k];
      end
    end
  end

  // Final reduction step and ratio clamp feeding the update stage
  logic [IdxW-1:0]            idx8;
  logic [ftpbs_pkg::SnrW-1:0] p8;

  always_comb begin
    idx8 = IdxW'(mod_step(pipe_q[NStage].rem, 0));
    if (pipe_q[NStage].sat) begin
      p8 = ftpbs_pkg::SnrMax;
    end else if (pipe_q[NStage].qn < ftpbs_pkg::SnrMin) begin
      p8 = ftpbs_pkg::SnrMin;
    end else begin
      p8 = pipe_q[NStage].qn;
    end
  end

  // Update stage registers
  logic [ftpbs_pkg::ChanW-1:0] s9_chan_q;
  logic [IdxW-1:0]             s9_idx_q;
  ftpbs_pkg::level_e           s9_lvl_q;
  logic [ftpbs_pkg::SnrW-1:0]  s9_p_q;
  ftpbs_pkg::chan_state_t      rd_q, fwd_data_q, cur, nxt;
  logic                        fwd_q;

  // Channel state memory
  ftpbs_pkg::chan_state_t mem [NUM_CHANNELS];
  logic                   we;
  logic [IdxW-1:0]        wa;
  ftpbs_pkg::chan_state_t wd;

  assign we = clr_busy_q || (adv && v9_q);
  assign wa = clr_busy_q ? clr_cnt_q : s9_idx_q;
  assign wd = clr_busy_q ? '0 : nxt;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (adv) begin
      rd_q <= mem[idx8];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s9_chan_q  <= pipe_q[NStage].chan;
      s9_idx_q   <= idx8;
      s9_lvl_q   <= pipe_q[NStage].lvl;
      s9_p_q     <= p8;
      fwd_data_q <= nxt;
    end
  end

  // State update: SNR smoothing and baud integration
  logic [ftpbs_pkg::SnrW:0]   up_d;
  logic [22:0]                dn_d;
  logic [ftpbs_pkg::CntW:0]   cnt_f;
  logic [ftpbs_pkg::CntW-1:0] n, cnt2;
  logic [ftpbs_pkg::SumW:0]   lvn;
  logic [ftpbs_pkg::SumW-1:0] sum2, mag, dlt, lvf, lvd;
  logic                       bvld, bval;

  assign cur = fwd_q ? fwd_data_q : rd_q;

  always_comb begin
    nxt  = cur;
    up_d = '0;
    dn_d = '0;
    if (s9_p_q >= cur.snr) begin
      up_d    = {1'b0, s9_p_q} - {1'b0, cur.snr} + 17'd2;
      nxt.snr = cur.snr + ftpbs_pkg::SnrW'(up_d >> 2);
    end else begin
      dn_d    = 23'(cur.snr - s9_p_q) * 23'(ftpbs_pkg::DecayMul) + ftpbs_pkg::DecayRound;
      nxt.snr = cur.snr - ftpbs_pkg::SnrW'(dn_d >> 10);
    end

    // Samples taken from this frame
    cnt_f = {1'b0, cur.cnt} + 17'(frame_q);
    if (cnt_f > 17'(baud_q)) begin
      n = (cur.cnt >= baud_q) ? '0 : baud_q - cur.cnt;
    end else begin
      n = 16'(frame_q);
    end
    cnt2 = cur.cnt + n;

    unique case (s9_lvl_q)
      ftpbs_pkg::LVL_MARK:  lvn = {2'b0, n};
      ftpbs_pkg::LVL_SPACE: lvn = -{2'b0, n};
      default:              lvn = '0;
    endcase
    sum2 = cur.sum + lvn[ftpbs_pkg::SumW-1:0];
    mag  = sum2[ftpbs_pkg::SumW-1] ? -sum2 : sum2;

    unique case (s9_lvl_q)
      ftpbs_pkg::LVL_MARK:  lvf = 17'(frame_q);
      ftpbs_pkg::LVL_SPACE: lvf = -17'(frame_q);
      default:              lvf = '0;
    endcase

    // Weak integral: resync to this frame
    if (mag < 17'(frame_q >> 1)) begin
      cnt2 = 16'(frame_q);
      sum2 = lvf;
    end

    // Period end: slice and carry over the rest of the frame
    dlt = 17'(frame_q) - 17'(n);
    unique case (s9_lvl_q)
      ftpbs_pkg::LVL_MARK:  lvd = dlt;
      ftpbs_pkg::LVL_SPACE: lvd = -dlt;
      default:              lvd = '0;
    endcase
    bvld = 1'b0;
    bval = 1'b0;
    if (cnt2 >= baud_q) begin
      bvld = (sum2 != '0);
      bval = (sum2 != '0) && !sum2[ftpbs_pkg::SumW-1];
      cnt2 = dlt[ftpbs_pkg::CntW-1:0];
      sum2 = lvd;
    end
    nxt.cnt = cnt2;
    nxt.sum = sum2;
  end

  // Output register
  logic [ftpbs_pkg::ChanW-1:0] out_chan_q;
  logic                        out_bvld_q, out_bval_q;
  logic [ftpbs_pkg::SnrW-1:0]  out_snr_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_chan_q <= s9_chan_q;
      out_bvld_q <= bvld;
      out_bval_q <= bval;
      out_snr_q  <= nxt.snr;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign channel_out_o = out_chan_q;
  assign bit_valid_o   = out_bvld_q;
  assign bit_value_o   = out_bval_q;
  assign snr_level_o   = out_snr_q;

  // Control registers: valid bits, bypass flag, clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q        <= '0;
      v9_q       <= 1'b0;
      out_vld_q  <= 1'b0;
      fwd_q      <= 1'b0;
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else begin
      if (adv) begin
        v_q       <= {v_q[NStage-1:0], in_valid_i && !clr_busy_q};
        v9_q      <= v_q[NStage];
        out_vld_q <= v9_q;
        fwd_q     <= v9_q && v_q[NStage] && (s9_idx_q == idx8);
      end
      if (clr_busy_q) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
        if (clr_cnt_q == IdxW'(NUM_CHANNELS - 1)) begin
          clr_busy_q <= 1'b0;
        end
      end
    end
  end

  // Checks
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(snr_level_o) &&
      $stable(channel_out_o))
    else $error("stalled result changed");

  a_bit_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !bit_valid_o |-> !bit_value_o)
    else $error("bit value set without valid");

  a_clr_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> in_stall_o && !v9_q)
    else $error("item in flight during clear");

  a_fwd_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_q |-> v9_q && $past(v9_q))
    else $error("bypass without a writer");

endmodule

// ----- dv/fsk_tone_pair_bit_slicer_test.sv -----
`timescale 1ns / 1ps

module fsk_tone_pair_bit_slicer_test;

  localparam int NCH = 512;
  localparam int CYCLE_LIMIT = 400000;
  // Index past the two registers, writes are ignored
  localparam logic [ftpbs_pkg::CfgIdxW-1:0] RegUnused = 2'd3;

  // One result item as seen on the output port
  typedef struct packed {
    logic [ftpbs_pkg::ChanW-1:0] chan;
    logic                        bvalid;
    logic                        bvalue;
    logic [ftpbs_pkg::SnrW-1:0]  snr;
  } slice_t;

  // Slicer model plus queue of expected result items
  class slice_board;
    int unsigned frame_len;
    int unsigned baud_len;
    logic [ftpbs_pkg::CntW-1:0] cnt_mem [NCH];
    logic [ftpbs_pkg::SumW-1:0] sum_mem [NCH];
    logic [ftpbs_pkg::SnrW-1:0] snr_mem [NCH];
    slice_t pending [$];
    int errors;

    function void clear();
      frame_len = ftpbs_pkg::FrameReset;
      baud_len = ftpbs_pkg::BaudReset;
      errors = 0;
      for (int i = 0; i < NCH; i++) begin
        cnt_mem[i] = '0;
        sum_mem[i] = '0;
        snr_mem[i] = '0;
      end
    endfunction

    function void set_reg(logic [ftpbs_pkg::CfgIdxW-1:0] idx,
                          logic [ftpbs_pkg::CfgDataW-1:0] val);
      if (idx == ftpbs_pkg::RegFrameSamples) frame_len = val[ftpbs_pkg::FrameW-1:0];
      else if (idx == ftpbs_pkg::RegBaudSamples) baud_len = val;
    endfunction

    // Predict the result of one accepted input item
    function void note_item(logic [ftpbs_pkg::ChanW-1:0] ch, logic [ftpbs_pkg::MagW-1:0] sp,
                            logic [ftpbs_pkg::MagW-1:0] mk, logic [ftpbs_pkg::MagW-1:0] fl);
      longint unsigned peak, flr, p, snr, cnt, n;
      longint sum, mag;
      int lvl, idx;
      slice_t r;
      idx = ch % NCH;
      flr = (fl == 0) ? 1 : fl;
      peak = (mk > sp) ? mk : sp;
      if (peak < 4 * flr) lvl = 0;
      else if (mk > 2 * longint'(sp)) lvl = 1;
      else if (sp > 2 * longint'(mk)) lvl = -1;
      else lvl = 0;
      p = (peak << 8) / flr;
      if (p > 65535) p = 65535;
      if (p < 256) p = 256;
      snr = snr_mem[idx];
      if (p >= snr) snr = snr + ((p - snr + 2) >> 2);
      else snr = snr - (((snr - p) * 51 + 512) >> 10);
      snr_mem[idx] = snr[15:0];
      cnt = cnt_mem[idx];
      sum = $signed(sum_mem[idx]);
      if (cnt + frame_len > baud_len) n = (cnt >= baud_len) ? 0 : baud_len - cnt;
      else n = frame_len;
      cnt = cnt + n;
      sum = sum + lvl * longint'(n);
      sum = $signed(sum[16:0]);
      mag = (sum < 0) ? -sum : sum;
      if (mag < frame_len / 2) begin
        cnt = frame_len;
        sum = lvl * longint'(frame_len);
      end
      r.chan = ch;
      r.bvalid = 1'b0;
      r.bvalue = 1'b0;
      if (cnt >= baud_len) begin
        if (sum != 0) begin
          r.bvalid = 1'b1;
          r.bvalue = (sum > 0);
        end
        cnt = frame_len - n;
        sum = lvl * longint'(cnt);
      end
      cnt_mem[idx] = cnt[15:0];
      sum_mem[idx] = sum[16:0];
      r.snr = snr_mem[idx];
      pending.push_back(r);
    endfunction

    function void check_result(slice_t got);
      slice_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result item %p", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.chan !== want.chan) begin
        $display("%0t: channel_out expected %0d actual %0d", $time, want.chan, got.chan);
        errors++;
      end
      if (got.bvalid !== want.bvalid) begin
        $display("%0t: bit_valid expected %0d actual %0d", $time, want.bvalid, got.bvalid);
        errors++;
      end
      if (got.bvalue !== want.bvalue) begin
        $display("%0t: bit_value expected %0d actual %0d", $time, want.bvalue, got.bvalue);
        errors++;
      end
      if (got.snr !== want.snr) begin
        $display("%0t: snr_level expected %0d actual %0d", $time, want.snr, got.snr);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [ftpbs_pkg::ChanW-1:0] channel_i = '0;
  logic [ftpbs_pkg::MagW-1:0] space_mag_i = '0, mark_mag_i = '0, noise_floor_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [ftpbs_pkg::ChanW-1:0] channel_out_o;
  logic bit_valid_o, bit_value_o;
  logic [ftpbs_pkg::SnrW-1:0] snr_level_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [ftpbs_pkg::CfgIdxW-1:0] cfg_index_i = '0;
  logic [ftpbs_pkg::CfgDataW-1:0] cfg_data_i = '0;

  slice_board board;
  int unsigned cycles = 0;
  bit rx_enable = 1'b0;

  fsk_tone_pair_bit_slicer #(.NUM_CHANNELS(NCH)) uut (.*);

  always #6 clk_i = ~clk_i;

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("fsk_tone_pair_bit_slicer verification failed");
      $finish;
    end
  end

  // Receiver: stall pattern alternating calm and busy stretches
  int stall_phase = 0;
  always @(posedge clk_i) begin
    if (rx_enable && out_valid_o && !out_stall_i)
      board.check_result({channel_out_o, bit_valid_o, bit_value_o, snr_level_o});
    stall_phase <= stall_phase + 1;
    if (!rx_enable || (stall_phase % 600) < 150) out_stall_i <= 1'b0;
    else out_stall_i <= ($urandom_range(0, 3) == 0);
  end

  task automatic write_reg(logic [ftpbs_pkg::CfgIdxW-1:0] idx,
                           logic [ftpbs_pkg::CfgDataW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    board.set_reg(idx, val);
    cfg_valid_i <= 1'b0;
  endtask

  // Present one item and hold it until accepted
  task automatic send_item(logic [ftpbs_pkg::ChanW-1:0] ch, logic [ftpbs_pkg::MagW-1:0] sp,
                           logic [ftpbs_pkg::MagW-1:0] mk, logic [ftpbs_pkg::MagW-1:0] fl);
    in_valid_i <= 1'b1;
    channel_i <= ch;
    space_mag_i <= sp;
    mark_mag_i <= mk;
    noise_floor_i <= fl;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_item(ch, sp, mk, fl);
  endtask

  task automatic idle(int n);
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic drain();
    idle(1);
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // Random item: mostly clean tones on channels below nch (any channel when nch >= NCH), some noise
  task automatic random_item(int nch);
    logic [ftpbs_pkg::MagW-1:0] sp, mk, fl;
    int kind;
    kind = $urandom_range(0, 9);
    fl = $urandom_range(1, 4096);
    if (kind < 4) begin
      mk = fl * $urandom_range(4, 200);
      sp = $urandom_range(0, mk / 3);
    end else if (kind < 8) begin
      sp = fl * $urandom_range(4, 200);
      mk = $urandom_range(0, sp / 3);
    end else begin
      fl = $urandom;
      sp = $urandom;
      mk = $urandom;
      if ($urandom_range(0, 5) == 0) fl = 0;
    end
    send_item((nch >= NCH) ? 9'($urandom) : 9'($urandom_range(0, nch - 1)), sp, mk, fl);
  endtask

  initial begin
    int frames [6] = '{564, 1, 32767, 100, 300, 5};
    int bauds [6] = '{1056, 1, 65535, 250, 900, 0};
    board = new();
    board.clear();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    rx_enable <= 1'b1;

    // Directed: extremes and special cases
    send_item(0, 0, 0, 0);
    send_item(511, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    send_item(511, 0, 24'hFFFFFF, 1);
    send_item(511, 24'hFFFFFF, 0, 1);
    send_item(3, 100, 400, 100);
    send_item(3, 100, 200, 50);
    send_item(3, 400, 100, 100);
    send_item(3, 400, 200, 100);
    send_item(3, 399, 0, 100);
    send_item(7, 24'h800000, 24'h400000, 24'h000001);
    send_item(7, 24'h555555, 24'hAAAAAA, 24'h000010);
    send_item(7, 1, 1, 24'hFFFFFF);
    for (int i = 0; i < 6; i++) send_item(9, 0, 24'h10000, 24'h100);
    drain();

    // Phases through register settings, including zero baud and ignored index
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(ftpbs_pkg::RegFrameSamples, 16'(frames[ph]) | 16'h8000);
      write_reg(ftpbs_pkg::RegBaudSamples, 16'(bauds[ph]));
      write_reg(RegUnused, 16'hFFFF);
      for (int k = 0; k < 325; k++) begin
        if (k % 20 == 0) idle($urandom_range(0, 6) * (ph % 2));
        random_item((ph == 3) ? NCH : (ph % 2 ? 4 : 2));
        if ($urandom_range(0, 7) == 0 && ph != 0) idle($urandom_range(1, 4));
      end
      drain();
    end

    if (board.errors == 0 && board.pending.size() == 0)
      $display("fsk_tone_pair_bit_slicer verification clean");
    else
      $display("fsk_tone_pair_bit_slicer verification failed");
    $finish;
  end
endmodule
